// ===== hdl/jse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned MaxRun  = 8;              // longest escaped run
  localparam int unsigned RunIdxW = $clog2(MaxRun);
  localparam int unsigned BodyMax = 6;              // \u00XX

  localparam logic [7:0] QuoteCh     = 8'h22;
  localparam logic [7:0] BackslashCh = 8'h5C;
  localparam logic [7:0] SlashCh     = 8'h2F;
  localparam logic [7:0] SpaceCh     = 8'h20;
  localparam logic [7:0] TildeMax    = 8'd126;
  localparam logic [3:0] NibbleMask  = 4'hF;
  localparam logic [7:0] HexAlpha    = 8'h41;       // 'A'
  localparam logic [7:0] DigitZero   = 8'h30;       // '0'
  localparam logic [7:0] LetterU     = 8'h75;       // 'u'

  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlCr  = 8'h0D;

  typedef enum logic [1:0] {
    CLS_PLAIN,    // byte passes through
    CLS_PREFIX,   // backslash then the byte itself
    CLS_SHORT,    // backslash then a letter
    CLS_UNICODE   // \u00XX
  } esc_cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic       empty;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ch;
    esc_cls_e   cls;
    logic [7:0] letter;
    logic       first;
    logic       last;
    logic       empty;
  } cls_word_t;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [RunIdxW-1:0]     last_idx;
  } run_word_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] val;
    val = {4'h0, nib & NibbleMask};
    if (nib < 4'd10) begin
      return DigitZero + val;
    end
    return HexAlpha + val - 8'd10;
  endfunction

endpackage

// ===== hdl/jse_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_classify
// First stage: decodes the raw byte into an escape class and short letter.
// ----------------------------------------------------------------------------
module jse_classify import jse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      up_valid_i,
  output logic      up_ready_o,
  input  in_word_t  up_word_i,
  output logic      dn_valid_o,
  input  logic      dn_ready_i,
  output cls_word_t dn_word_o
);

  logic      valid_q, valid_d;
  cls_word_t word_q, word_d;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_comb begin
    word_d.ch     = up_word_i.ch;
    word_d.first  = up_word_i.first;
    word_d.last   = up_word_i.last;
    word_d.empty  = up_word_i.empty;
    word_d.letter = up_word_i.ch;
    word_d.cls    = CLS_PLAIN;
    case (up_word_i.ch)
      QuoteCh, BackslashCh, SlashCh: word_d.cls = CLS_PREFIX;
      CtlBs:  begin word_d.cls = CLS_SHORT; word_d.letter = 8'h62; end // b
      CtlFf:  begin word_d.cls = CLS_SHORT; word_d.letter = 8'h66; end // f
      CtlLf:  begin word_d.cls = CLS_SHORT; word_d.letter = 8'h6E; end // n
      CtlCr:  begin word_d.cls = CLS_SHORT; word_d.letter = 8'h72; end // r
      CtlTab: begin word_d.cls = CLS_SHORT; word_d.letter = 8'h74; end // t
      default: begin
        if (up_word_i.ch < SpaceCh || up_word_i.ch > TildeMax) begin
          word_d.cls = CLS_UNICODE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

// ===== hdl/jse_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_expand
// Second stage: lays out the whole escaped run, quotes included.
// ----------------------------------------------------------------------------
module jse_expand import jse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      up_valid_i,
  output logic      up_ready_o,
  input  cls_word_t up_word_i,
  output logic      dn_valid_o,
  input  logic      dn_ready_i,
  output run_word_t dn_word_o
);

  logic      valid_q, valid_d;
  run_word_t word_q, word_d;

  logic [BodyMax-1:0][7:0] body;
  logic [3:0]              body_len;
  logic [3:0]              pos;
  logic [3:0]              run_len;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_comb begin
    body     = '0;
    body_len = 4'd2;
    pos      = '0;
    case (up_word_i.cls)
      CLS_PLAIN: begin
        body[0]  = up_word_i.ch;
        body_len = 4'd1;
      end
      CLS_PREFIX: begin
        body[0] = BackslashCh;
        body[1] = up_word_i.ch;
      end
      CLS_SHORT: begin
        body[0] = BackslashCh;
        body[1] = up_word_i.letter;
      end
      default: begin
        body[0]  = BackslashCh;
        body[1]  = LetterU;
        body[2]  = DigitZero;
        body[3]  = DigitZero;
        body[4]  = hex_digit(up_word_i.ch[7:4]);
        body[5]  = hex_digit(up_word_i.ch[3:0]);
        body_len = 4'd6;
      end
    endcase

    word_d.bytes = '0;
    if (up_word_i.empty) begin
      word_d.bytes[0] = QuoteCh;
      word_d.bytes[1] = QuoteCh;
      run_len         = 4'd2;
    end else begin
      for (int i = 0; i < MaxRun; i++) begin
        // position inside the body once the opening quote is skipped
        pos = 4'(i) - {3'b0, up_word_i.first};
        if (i == 0 && up_word_i.first) begin
          word_d.bytes[i] = QuoteCh;
        end else if (pos < body_len) begin
          word_d.bytes[i] = body[pos[2:0]];
        end else if (pos == body_len && up_word_i.last) begin
          word_d.bytes[i] = QuoteCh;
        end
      end
      run_len = body_len + {3'b0, up_word_i.first} + {3'b0, up_word_i.last};
    end
    word_d.last_idx = RunIdxW'(run_len - 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

// ===== hdl/jse_serialize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_serialize
// Output stage: holds one run and hands out its bytes one by one, holding while the output stalls.
// ----------------------------------------------------------------------------
module jse_serialize import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       up_valid_i,
  output logic       up_ready_o,
  input  run_word_t  up_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic               busy_q, busy_d;
  logic [RunIdxW-1:0] idx_q, idx_d;
  run_word_t          run_q;
  logic               take, fin, load;

  assign take = busy_q && !out_stall_i;
  assign fin  = take && (idx_q == run_q.last_idx);
  // next run loads the cycle the last byte of the current one leaves
  assign up_ready_o = !busy_q || fin;
  assign load       = up_ready_o && up_valid_i;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + RunIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= up_word_i;
    end
  end

  assign out_valid_o   = busy_q;
  assign out_byte_o    = run_q.bytes[idx_q];
  assign last_of_run_o = (idx_q == run_q.last_idx);

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= run_q.last_idx)
    else $error("byte index past end of run");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && idx_q == '0)
    else $error("loaded run does not start at its first byte");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && !up_valid_i |=> !busy_q)
    else $error("serializer stays busy after its last byte");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !fin |=> idx_q == $past(idx_q) + RunIdxW'(1))
    else $error("byte index did not advance on a taken word");

endmodule

// ===== hdl/json_string_escaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper
// Escapes a byte stream into JSON string text, quotes included.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | char_byte, first/last_in_string, empty
//   out     | out_valid_o/out_stall_i | out_byte, last_of_run
//
// Three stages: classify, expand, serialize. A run of 1 to 8 output bytes
// leaves at one byte per cycle while the output does not stall, and the
// serializer takes the next run only as the last byte of its run leaves.
// Plain bytes flow at one word per cycle while the output does not stall.
// Reset clears the valid bits and the serializer's byte index only. A stall
// at the output backs up stage by stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       first_in_string_i,
  input  logic       last_in_string_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  in_word_t  in_word;
  cls_word_t cls_word;
  run_word_t run_word;
  logic      in_ready, cls_valid, cls_ready, run_valid, run_ready;

  assign in_word.ch    = char_byte_i;
  assign in_word.first = first_in_string_i;
  assign in_word.last  = last_in_string_i;
  assign in_word.empty = empty_string_i;
  assign in_stall_o    = !in_ready;

  jse_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready),
    .up_word_i  (in_word),
    .dn_valid_o (cls_valid),
    .dn_ready_i (cls_ready),
    .dn_word_o  (cls_word)
  );

  jse_expand u_expand (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (cls_valid),
    .up_ready_o (cls_ready),
    .up_word_i  (cls_word),
    .dn_valid_o (run_valid),
    .dn_ready_i (run_ready),
    .dn_word_o  (run_word)
  );

  jse_serialize u_serialize (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_valid_i    (run_valid),
    .up_ready_o    (run_ready),
    .up_word_i     (run_word),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== dv/tb_json_string_escaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking bench for the JSON string escaper. A driver sends raw string
// bytes with their flags, and a monitor compares every escaped output byte
// and its end-of-run flag with a predicted byte stream. The bench covers
// directed corner bytes, then random strings and some noise. Both sides idle
// at random. There is one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
  import jse_pkg::*;

  localparam int unsigned RandomWords = 360;
  localparam int unsigned HangLimit   = 1000;  // cycles with no handshake
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PressAfter  = 80;    // output bytes before long hold
  localparam int unsigned PressLength = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_byte_i       = 8'h00;
  logic       first_in_string_i = 1'b0;
  logic       last_in_string_i  = 1'b0;
  logic       empty_string_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  in_word_t   pending_words[$];
  in_word_t   cur_word;
  text_byte_t escaped_text[$];
  text_byte_t want;

  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned bytes_seen     = 0;
  int unsigned fail_count     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned send_calm      = 0;
  int unsigned send_roll;
  int unsigned hold_left      = 0;
  int unsigned recv_calm      = 0;
  int unsigned recv_roll;
  bit          press_done     = 1'b0;

  json_string_escaper u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_byte_i      (char_byte_i),
    .first_in_string_i(first_in_string_i),
    .last_in_string_i (last_in_string_i),
    .empty_string_i   (empty_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  always #6 clk_i = ~clk_i;

  // Appends the escaped text of one accepted word to the expected stream.
  function automatic void escape_word(in_word_t w);
    logic [7:0] run[$];
    string      hex_set;
    int         i;
    hex_set = "0123456789ABCDEF";
    if (w.empty) begin
      run.push_back(QuoteCh);
      run.push_back(QuoteCh);
    end else begin
      if (w.first) begin
        run.push_back(QuoteCh);
      end
      case (w.ch)
        QuoteCh, BackslashCh, SlashCh: begin
          run.push_back(BackslashCh);
          run.push_back(w.ch);
        end
        CtlBs: begin
          run.push_back(BackslashCh);
          run.push_back("b");
        end
        CtlFf: begin
          run.push_back(BackslashCh);
          run.push_back("f");
        end
        CtlLf: begin
          run.push_back(BackslashCh);
          run.push_back("n");
        end
        CtlCr: begin
          run.push_back(BackslashCh);
          run.push_back("r");
        end
        CtlTab: begin
          run.push_back(BackslashCh);
          run.push_back("t");
        end
        default: begin
          if (w.ch < SpaceCh || w.ch > TildeMax) begin
            run.push_back(BackslashCh);
            run.push_back("u");
            run.push_back("0");
            run.push_back("0");
            run.push_back(hex_set[w.ch[7:4]]);
            run.push_back(hex_set[w.ch[3:0]]);
          end else begin
            run.push_back(w.ch);
          end
        end
      endcase
      if (w.last) begin
        run.push_back(QuoteCh);
      end
    end
    for (i = 0; i < run.size(); i++) begin
      escaped_text.push_back('{ch: run[i], last: (i == run.size() - 1)});
    end
  endfunction

  task automatic queue_word(logic [7:0] ch, logic first, logic last, logic empty);
    pending_words.push_back('{ch: ch, first: first, last: last, empty: empty});
    words_queued++;
  endtask

  // Mostly printable text, with a good share of escape candidates.
  function automatic logic [7:0] random_text_byte();
    logic [7:0] specials[8];
    specials = '{QuoteCh, BackslashCh, SlashCh, CtlBs, CtlFf, CtlLf, CtlCr, CtlTab};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'($urandom_range(8'h20, 8'h7E));
      5, 6:          return specials[$urandom_range(7)];
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Input driver: payload only changes when the current word is taken or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i        <= 1'b0;
      char_byte_i       <= 8'h00;
      first_in_string_i <= 1'b0;
      last_in_string_i  <= 1'b0;
      empty_string_i    <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        escape_word(cur_word);
        words_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_valid_i        <= 1'b1;
          char_byte_i       <= cur_word.ch;
          first_in_string_i <= cur_word.first;
          last_in_string_i  <= cur_word.last;
          empty_string_i    <= cur_word.empty;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_roll = $urandom_range(99);
            if (send_roll < 3) begin
              send_calm = $urandom_range(10, 40);
            end
            if (send_roll < 45) begin
              send_gap = 0;
            end else if (send_roll < 93) begin
              send_gap = $urandom_range(1, 3);
            end else begin
              send_gap = $urandom_range(8, 40);
            end
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        bytes_seen++;
        if (escaped_text.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h last %b", out_byte_o, last_of_run_o));
        end else begin
          want = escaped_text.pop_front();
          if (out_byte_o !== want.ch) begin
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte_o, want.ch));
          end
          if (last_of_run_o !== want.last) begin
            report_mismatch($sformatf("last_of_run %b, expected %b on byte %h",
                                      last_of_run_o, want.last, want.ch));
          end
        end
      end
      // one long hold so the pipeline fills and stalls its input
      if (!press_done && bytes_seen >= PressAfter) begin
        press_done = 1'b1;
        hold_left  = PressLength;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (recv_calm > 0) begin
        out_stall_i <= 1'b0;
        recv_calm--;
      end else begin
        recv_roll = $urandom_range(99);
        if (recv_roll < 50) begin
          out_stall_i <= 1'b0;
        end else if (recv_roll < 55) begin
          out_stall_i <= 1'b0;
          recv_calm = $urandom_range(10, 60);
        end else if (recv_roll < 96) begin
          out_stall_i <= 1'b1;
          hold_left = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          hold_left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("timeout: no handshake for %0d cycles", HangLimit);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty strings, one-byte strings, every escape class, extremes
    queue_word(QuoteCh, 1'b0, 1'b0, 1'b1);
    queue_word(8'hFF, 1'b1, 1'b1, 1'b1);
    queue_word(8'h41, 1'b1, 1'b1, 1'b0);
    queue_word(8'hAB, 1'b1, 1'b1, 1'b0);        // longest run
    queue_word(8'h00, 1'b1, 1'b0, 1'b0);        // zero byte is escaped as \u0000
    queue_word(QuoteCh, 1'b0, 1'b0, 1'b0);
    queue_word(BackslashCh, 1'b0, 1'b0, 1'b0);
    queue_word(SlashCh, 1'b0, 1'b0, 1'b0);
    queue_word(CtlBs, 1'b0, 1'b0, 1'b0);
    queue_word(CtlFf, 1'b0, 1'b0, 1'b0);
    queue_word(CtlLf, 1'b0, 1'b0, 1'b0);
    queue_word(CtlCr, 1'b0, 1'b0, 1'b0);
    queue_word(CtlTab, 1'b0, 1'b0, 1'b0);
    queue_word(8'h1F, 1'b0, 1'b0, 1'b0);
    queue_word(SpaceCh, 1'b0, 1'b0, 1'b0);
    queue_word(8'h7E, 1'b0, 1'b0, 1'b0);
    queue_word(8'h7F, 1'b0, 1'b0, 1'b0);
    queue_word(8'h80, 1'b0, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_word(8'h5A, 1'b0, 1'b1, 1'b0);
    wait (words_accepted == words_queued && escaped_text.size() == 0);

    // random strings, with a little noise mixed in
    while (words_queued < RandomWords) begin
      if ($urandom_range(9) == 0) begin
        queue_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), ($urandom_range(7) == 0));
      end else begin
        len = $urandom_range(0, 12);
        if (len == 0) begin
          queue_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'b1);
        end
        for (k = 0; k < len; k++) begin
          queue_word(random_text_byte(), (k == 0), (k == len - 1), 1'b0);
        end
      end
    end
    wait (words_accepted == words_queued && escaped_text.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jse_pkg.sv
hdl/jse_classify.sv
hdl/jse_expand.sv
hdl/jse_serialize.sv
hdl/json_string_escaper.sv
dv/tb_json_string_escaper.sv
